/* rtl/rbh_pkg.sv */
// Package for the ray / box crossing test: default widths and the axis count.
// No dependencies.
`default_nettype none
package rbh_pkg;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_AXES       = 3;
endpackage
`default_nettype wire

/* rtl/ray_box_hit_test.sv */
// Ray / axis-aligned box crossing test, exact by cross-multiplication.
// Takes one input transaction per cycle while the output is not held.
// Stages: differences, products, sums, sign compare and OR; a stall holds all.
// Reset clears the valid bits only. Depends on rbh_pkg and rbh_mul.
`default_nettype none
module ray_box_hit_test #(
  parameter int COORD_BITS = rbh_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rbh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] origin_x,
  input  wire logic signed [COORD_BITS-1:0] origin_y,
  input  wire logic signed [COORD_BITS-1:0] origin_z,
  input  wire logic signed [COORD_BITS-1:0] dir_x,
  input  wire logic signed [COORD_BITS-1:0] dir_y,
  input  wire logic signed [COORD_BITS-1:0] dir_z,
  input  wire logic signed [COORD_BITS-1:0] box_min_x,
  input  wire logic signed [COORD_BITS-1:0] box_min_y,
  input  wire logic signed [COORD_BITS-1:0] box_min_z,
  input  wire logic signed [COORD_BITS-1:0] box_max_x,
  input  wire logic signed [COORD_BITS-1:0] box_max_y,
  input  wire logic signed [COORD_BITS-1:0] box_max_z,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              hit
);
  import rbh_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = DW + CW;
  localparam int SW = PW + 1;
  localparam int NA = NUM_AXES;
  localparam int FRAC_CHECK = FRAC_BITS;

  logic [3:0] vld;
  logic       adv;
  logic       h;

  // Every stage advances together; a held result stalls the whole pipe.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic signed [CW-1:0] o [NA];
  logic signed [CW-1:0] d [NA];
  logic signed [CW-1:0] bmn [NA];
  logic signed [CW-1:0] bmx [NA];

  always_comb begin
    o[0] = origin_x;   o[1] = origin_y;   o[2] = origin_z;
    d[0] = dir_x;      d[1] = dir_y;      d[2] = dir_z;
    bmn[0] = box_min_x; bmn[1] = box_min_y; bmn[2] = box_min_z;
    bmx[0] = box_max_x; bmx[1] = box_max_y; bmx[2] = box_max_z;
  end

  // Stage 1: differences.
  logic signed [DW-1:0] s1_dpmax [NA];
  logic signed [DW-1:0] s1_dpmin [NA];
  logic signed [DW-1:0] s1_omin [NA];
  logic signed [DW-1:0] s1_omax [NA];
  logic signed [CW-1:0] s1_d [NA];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NA; i++) begin
        s1_dpmax[i] <= DW'(bmx[i]) - DW'(o[i]);
        s1_dpmin[i] <= DW'(bmn[i]) - DW'(o[i]);
        s1_omin[i]  <= DW'(o[i]) - DW'(bmn[i]);
        s1_omax[i]  <= DW'(o[i]) - DW'(bmx[i]);
        s1_d[i]     <= d[i];
      end
    end
  end

  // Stage 2: products. cmx/cmn: plane offset times d[b]; pmn/pmx: bound term times d[a].
  logic signed [PW-1:0] cmx [NA][NA];
  logic signed [PW-1:0] cmn [NA][NA];
  logic signed [PW-1:0] pmn [NA][NA];
  logic signed [PW-1:0] pmx [NA][NA];
  logic signed [CW-1:0] s2_d [NA];

  for (genvar a = 0; a < NA; a++) begin : g_a
    for (genvar b = 0; b < NA; b++) begin : g_b
      rbh_mul #(.AW(DW), .BW(CW)) u_cmx (
        .clk(clk), .en(adv), .a(s1_dpmax[a]), .b(s1_d[b]), .p(cmx[a][b]));
      rbh_mul #(.AW(DW), .BW(CW)) u_cmn (
        .clk(clk), .en(adv), .a(s1_dpmin[a]), .b(s1_d[b]), .p(cmn[a][b]));
      rbh_mul #(.AW(DW), .BW(CW)) u_pmn (
        .clk(clk), .en(adv), .a(s1_omin[b]), .b(s1_d[a]), .p(pmn[a][b]));
      rbh_mul #(.AW(DW), .BW(CW)) u_pmx (
        .clk(clk), .en(adv), .a(s1_omax[b]), .b(s1_d[a]), .p(pmx[a][b]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_d <= s1_d;
    end
  end

  // Stage 3: sums for each face (f: 0 max plane, 1 min plane), axis a, other b.
  logic signed [SW-1:0] lo_s [2][NA][NA];
  logic signed [SW-1:0] hi_s [2][NA][NA];
  logic                 s3_neg [NA];
  logic                 s3_nz [NA];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NA; a++) begin
        s3_neg[a] <= s2_d[a][CW-1];
        s3_nz[a]  <= |s2_d[a];
        for (int b = 0; b < NA; b++) begin
          lo_s[0][a][b] <= SW'(pmn[a][b]) + SW'(cmx[a][b]);
          hi_s[0][a][b] <= SW'(pmx[a][b]) + SW'(cmx[a][b]);
          lo_s[1][a][b] <= SW'(pmn[a][b]) + SW'(cmn[a][b]);
          hi_s[1][a][b] <= SW'(pmx[a][b]) + SW'(cmn[a][b]);
        end
      end
    end
  end

  // Stage 4: signs against direction sign, OR over faces.
  always_comb begin
    logic ok;
    logic lp;
    logic hn;
    h = 1'b0;
    for (int f = 0; f < 2; f++) begin
      for (int a = 0; a < NA; a++) begin
        ok = s3_nz[a];
        for (int b = 0; b < NA; b++) begin
          if (b != a) begin
            if (s3_neg[a]) begin
              lp = lo_s[f][a][b][SW-1];
              hn = !hi_s[f][a][b][SW-1] && (|hi_s[f][a][b]);
            end else begin
              lp = !lo_s[f][a][b][SW-1] && (|lo_s[f][a][b]);
              hn = hi_s[f][a][b][SW-1];
            end
            ok = ok && lp && hn;
          end
        end
        h = h || ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= h && (FRAC_CHECK >= 0);
    end
  end

  assign out_valid = vld[3];
endmodule
`default_nettype wire

/* rtl/rbh_mul.sv */
// Registered signed multiplier with enable.
// Depends on nothing.
`default_nettype none
module rbh_mul #(
  parameter int AW = 33,
  parameter int BW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end
endmodule
`default_nettype wire

/* bench/rbh_checker.sv */
// Checker for ray_box_hit_test: watches both channels, predicts hit for each
// input transaction and compares it with the returned result. Depends on rbh_pkg.
`timescale 1ns / 100ps
module rbh_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [31:0] origin_x,
  input  wire logic signed [31:0] origin_y,
  input  wire logic signed [31:0] origin_z,
  input  wire logic signed [31:0] dir_x,
  input  wire logic signed [31:0] dir_y,
  input  wire logic signed [31:0] dir_z,
  input  wire logic signed [31:0] box_min_x,
  input  wire logic signed [31:0] box_min_y,
  input  wire logic signed [31:0] box_min_z,
  input  wire logic signed [31:0] box_max_x,
  input  wire logic signed [31:0] box_max_y,
  input  wire logic signed [31:0] box_max_z,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic               hit,
  output int                      fail_count,
  output int                      pending
);
  typedef logic signed [32:0] vec_t [rbh_pkg::NUM_AXES];

  bit hit_queue[$];

  function automatic int sign_of(input logic signed [99:0] v);
    if (v < 0) return -1;
    if (v == 0) return 0;
    return 1;
  endfunction

  function automatic bit face_crossed(input vec_t o, input vec_t d, input vec_t lo,
                                      input vec_t hi, input int ax,
                                      input logic signed [32:0] plane);
    int sa;
    logic signed [33:0] dp;
    logic signed [99:0] cr_term, s_lo, s_hi;
    if (d[ax] == 0) return 1'b0;
    sa = (d[ax] > 0) ? 1 : -1;
    dp = plane - o[ax];
    for (int b = 0; b < 3; b++) begin
      if (b == ax) continue;
      cr_term = dp * d[b];
      s_lo = (o[b] - lo[b]) * d[ax] + cr_term;
      s_hi = (o[b] - hi[b]) * d[ax] + cr_term;
      if (sign_of(s_lo) * sa <= 0) return 1'b0;
      if (sign_of(s_hi) * sa >= 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit predict_hit(input vec_t o, input vec_t d, input vec_t lo,
                                     input vec_t hi);
    bit h;
    h = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      if (face_crossed(o, d, lo, hi, ax, hi[ax])) h = 1'b1;
      if (face_crossed(o, d, lo, hi, ax, lo[ax])) h = 1'b1;
    end
    return h;
  endfunction

  assign pending = hit_queue.size();

  always @(posedge clk) begin
    vec_t o, d, lo, hi;
    bit exp_hit;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        o  = '{origin_x, origin_y, origin_z};
        d  = '{dir_x, dir_y, dir_z};
        lo = '{box_min_x, box_min_y, box_min_z};
        hi = '{box_max_x, box_max_y, box_max_z};
        hit_queue.push_back(predict_hit(o, d, lo, hi));
      end
      if (out_valid && out_ready) begin
        if (hit_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result: hit=%0b", hit);
          fail_count <= fail_count + 1;
        end else begin
          exp_hit = hit_queue.pop_front();
          if (hit !== exp_hit) begin
            if (fail_count < 10)
              $display("hit mismatch: expected %0b, actual %0b", exp_hit, hit);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* bench/tb_ray_box_hit_test.sv */
// Testbench top for ray_box_hit_test: reset, directed and random stimulus with
// idling phases and a long output hold-off. Depends on rbh_checker and the RTL.
`timescale 1ns / 100ps
module tb_ray_box_hit_test;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic signed [31:0] f [12];
  logic in_ready, out_valid, hit;
  int fail_count, pending;
  int idle_pct = 0, stall_pct = 0;
  bit hold_off = 1'b0;
  int cycles = 0;

  always #1 clk = ~clk;

  ray_box_hit_test u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .origin_x(f[0]), .origin_y(f[1]), .origin_z(f[2]),
    .dir_x(f[3]), .dir_y(f[4]), .dir_z(f[5]),
    .box_min_x(f[6]), .box_min_y(f[7]), .box_min_z(f[8]),
    .box_max_x(f[9]), .box_max_y(f[10]), .box_max_z(f[11]),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
  );

  rbh_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .origin_x(f[0]), .origin_y(f[1]), .origin_z(f[2]),
    .dir_x(f[3]), .dir_y(f[4]), .dir_z(f[5]),
    .box_min_x(f[6]), .box_min_y(f[7]), .box_min_z(f[8]),
    .box_max_x(f[9]), .box_max_y(f[10]), .box_max_z(f[11]),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
    .fail_count(fail_count), .pending(pending)
  );

  initial for (int i = 0; i < 12; i++) f[i] = '0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(8192)) - 4096;
      2: return $signed($urandom_range(20)) - 10;
      default: return 32'sd0;
    endcase
  endfunction

  task automatic send(input logic signed [31:0] v [12]);
    for (int i = 0; i < 12; i++) f[i] <= v[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic signed [31:0] v [12];
    logic signed [31:0] t;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 12; i++)
      v[i] = rand_coord(mode < 2 ? 0 : (mode < 7 ? 1 : 2));
    if (mode >= 1 && mode < 8)
      for (int a = 0; a < 3; a++)
        if (v[6+a] > v[9+a]) begin
          t = v[6+a];
          v[6+a] = v[9+a];
          v[9+a] = t;
        end
    if ($urandom_range(7) == 0) v[3 + $urandom_range(2)] = 0;
    send(v);
  endtask

  task automatic send_directed(input int kind);
    logic signed [31:0] v [12];
    for (int i = 0; i < 3; i++) begin
      v[i] = 0; v[3+i] = 0; v[6+i] = -32'sd65536; v[9+i] = 32'sd65536;
    end
    case (kind)
      0: ;
      1: v[3] = 32'sd65536;
      2: v[4] = -32'sd1;
      3: begin v[0] = -32'sd655360; v[3] = 32'sd65536; v[1] = 32'sd65536; end
      4: begin v[0] = 32'sd655360; v[3] = 32'sd65536; end
      5: begin v[3] = 1; v[4] = 1; v[5] = 1; end
      6: begin v[6] = 32'sd65536; v[9] = -32'sd65536; v[4] = 1; end
      7: begin v[7] = 0; v[10] = 0; v[3] = 1; end
      8: for (int i = 0; i < 12; i++) v[i] = 32'h7fffffff;
      9: for (int i = 0; i < 12; i++) v[i] = 32'h80000000;
      10: begin
        for (int i = 0; i < 6; i++) v[i] = 32'h7fffffff;
        for (int i = 6; i < 9; i++) v[i] = 32'h80000000;
        for (int i = 9; i < 12; i++) v[i] = 32'h7fffffff;
      end
      11: begin
        for (int i = 0; i < 3; i++) v[i] = 32'h80000000;
        for (int i = 3; i < 6; i++) v[i] = 32'h7fffffff;
        for (int i = 6; i < 9; i++) v[i] = 32'h80000001;
        for (int i = 9; i < 12; i++) v[i] = 32'h7ffffffe;
      end
      12: begin v[2] = -32'sd65536; v[5] = 32'sd65536; v[0] = 32'sd65536; end
      13: begin v[0] = 5; v[3] = -32'sd3; v[4] = 32'sd7; v[5] = -32'sd11; end
      default: for (int i = 0; i < 12; i++) v[i] = $urandom;
    endcase
    send(v);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 16; k++) send_directed(k);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      for (int n = 0; n < 500; n++) send_random();
    end
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        for (int c = 0; c < 60; c++) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 40; n++) send_random();
    join
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
